// ===== rtl/ihex_pkg.sv =====
// Shared types, constants and the hex digit decode for the HEX record parser.
`timescale 1ns / 1ps

package ihex_pkg;

	// Address arithmetic width (16 to 32); emitted addresses are taken modulo 2^ADDR_WIDTH.
	localparam int ADDR_WIDTH = 32;
	localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFF >> (32 - ADDR_WIDTH);

	// Token queue between the character front and the record back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UC_A  = 8'h41;
	localparam logic [7:0] CHAR_UC_F  = 8'h46;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_LC_F  = 8'h66;
	localparam logic [7:0] DIGIT_TEN  = 8'd10;

	localparam logic [7:0] REC_DATA     = 8'h00;
	localparam logic [7:0] REC_EOF      = 8'h01;
	localparam logic [7:0] REC_EXT_LIN  = 8'h04;

	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_REC_END = 1'b1;

	// One classified item from the front: a record start or a decoded byte.
	typedef struct packed {
		logic       is_start;
		logic [7:0] value;
	} token_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] addr;
		logic [7:0]  data;
		logic [7:0]  rtype;
		logic        good;
		logic        eof;
	} result_t;

	// Non-hex characters count as zero.
	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
			d = c - CHAR_ZERO;
		end else if (c inside {[CHAR_UC_A:CHAR_UC_F]}) begin
			d = c - CHAR_UC_A + DIGIT_TEN;
		end else if (c inside {[CHAR_LC_A:CHAR_LC_F]}) begin
			d = c - CHAR_LC_A + DIGIT_TEN;
		end
		return d[3:0];
	endfunction

endpackage

// ===== rtl/ihex_front.sv =====
// Character front: pairs hex digits into bytes and flags record starts.
`timescale 1ns / 1ps

module ihex_front import ihex_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	output logic       push,
	output token_t     push_tok,
	input  logic       fifo_full
);

	logic       pending_q;
	logic [3:0] high_q;
	logic       accept;
	logic       is_colon;
	logic [3:0] digit;

	assign char_stall = fifo_full;
	assign accept     = char_valid && !char_stall;
	assign is_colon   = (char_code == CHAR_COLON);
	assign digit      = digit_value(char_code);

	// Push a start token on a colon, a byte token on the second digit of a pair.
	assign push              = accept && (is_colon || pending_q);
	assign push_tok.is_start = is_colon;
	assign push_tok.value    = is_colon ? 8'h00 : {high_q, digit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			high_q    <= 4'h0;
		end else if (accept) begin
			if (is_colon) begin
				pending_q <= 1'b0;
				high_q    <= 4'h0;
			end else if (!pending_q) begin
				pending_q <= 1'b1;
				high_q    <= digit;
			end else begin
				pending_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/ihex_token_fifo.sv =====
// Short token queue that decouples the character front from the record back.
`timescale 1ns / 1ps

module ihex_token_fifo import ihex_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  token_t push_tok,
	output logic   full,
	output logic   tok_valid,
	output token_t tok,
	input  logic   pop
);

	token_t                entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full      = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign tok_valid = (count_q != '0);
	assign tok       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ihex_back.sv =====
// Record back end: walks the record fields and drives the result register.
`timescale 1ns / 1ps

module ihex_back import ihex_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    word_addressing,
	input  logic    tok_valid,
	input  token_t  tok,
	output logic    pop,
	output logic    res_valid,
	input  logic    res_stall,
	output result_t res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEN,
		PH_OFS_HI,
		PH_OFS_LO,
		PH_TYPE,
		PH_DATA,
		PH_CSUM
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  rem_q, rem_d;
	logic [15:0] ofs_q, ofs_d;
	logic [7:0]  kind_q, kind_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] base_q, base_d;
	logic [15:0] shadow_q, shadow_d;
	logic        res_valid_q;
	result_t     res_q;

	logic        out_free;
	logic        emit;
	result_t     emit_res;
	logic [7:0]  sum_add;
	logic [7:0]  idx;
	logic [7:0]  rem_dec;
	logic [31:0] addr_full;

	assign out_free  = !res_valid_q || !res_stall;
	assign pop       = tok_valid && out_free;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign sum_add   = sum_q + tok.value;
	assign idx       = len_q - rem_q;
	assign rem_dec   = rem_q - 8'd1;
	assign addr_full = ({base_q, 16'h0000} + {16'h0000, ofs_q} + {24'h000000, idx}) & ADDR_MASK;

	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		rem_d    = rem_q;
		ofs_d    = ofs_q;
		kind_d   = kind_q;
		sum_d    = sum_q;
		base_d   = base_q;
		shadow_d = shadow_q;
		emit     = 1'b0;
		emit_res = '0;
		if (pop) begin
			if (tok.is_start) begin
				phase_d = PH_LEN;
				sum_d   = 8'h00;
			end else if (phase_q != PH_IDLE) begin
				sum_d = sum_add;
				case (phase_q)
					PH_LEN: begin
						len_d   = tok.value;
						phase_d = PH_OFS_HI;
					end
					PH_OFS_HI: begin
						ofs_d   = {tok.value, 8'h00};
						phase_d = PH_OFS_LO;
					end
					PH_OFS_LO: begin
						ofs_d   = {ofs_q[15:8], tok.value};
						phase_d = PH_TYPE;
					end
					PH_TYPE: begin
						kind_d   = tok.value;
						rem_d    = len_q;
						shadow_d = 16'h0000;
						phase_d  = (len_q != 8'h00) ? PH_DATA : PH_CSUM;
					end
					PH_DATA: begin
						rem_d = rem_dec;
						if (rem_dec == 8'h00) begin
							phase_d = PH_CSUM;
						end
						if (kind_q == REC_DATA) begin
							emit          = 1'b1;
							emit_res.kind = KIND_DATA;
							emit_res.addr = word_addressing ? {1'b0, addr_full[31:1]} : addr_full;
							emit_res.data = tok.value;
						end else if (kind_q == REC_EXT_LIN) begin
							if (idx == 8'd0) begin
								shadow_d = {tok.value, shadow_q[7:0]};
							end else if (idx == 8'd1) begin
								shadow_d = {shadow_q[15:8], tok.value};
							end
						end
					end
					PH_CSUM: begin
						emit           = 1'b1;
						emit_res.kind  = KIND_REC_END;
						emit_res.rtype = kind_q;
						emit_res.good  = (sum_add == 8'h00);
						emit_res.eof   = (kind_q == REC_EOF);
						if ((sum_add == 8'h00) && (kind_q == REC_EXT_LIN)) begin
							base_d = shadow_q;
						end
						phase_d = PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			len_q       <= 8'h00;
			rem_q       <= 8'h00;
			ofs_q       <= 16'h0000;
			kind_q      <= 8'h00;
			sum_q       <= 8'h00;
			base_q      <= 16'h0000;
			shadow_q    <= 16'h0000;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			rem_q    <= rem_d;
			ofs_q    <= ofs_d;
			kind_q   <= kind_d;
			sum_q    <= sum_d;
			base_q   <= base_d;
			shadow_q <= shadow_d;
			if (out_free) begin
				res_valid_q <= emit;
			end
			if (emit) begin
				res_q <= emit_res;
			end
		end
	end

	// A data phase always has at least one byte left.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> rem_q != 8'h00)
		else $error("data phase with no bytes remaining");

	// The checksum byte closes the record.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !tok.is_start && phase_q == PH_CSUM |=> phase_q == PH_IDLE && res_valid_q)
		else $error("checksum byte did not close the record");

	// Bytes outside a record never produce a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !tok.is_start && phase_q == PH_IDLE |-> !emit)
		else $error("result produced outside a record");

	// End of file is flagged only on a record end of type one.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.eof |-> res_q.kind == KIND_REC_END && res_q.rtype == REC_EOF)
		else $error("end of file flag on wrong result");

endmodule

// ===== rtl/intel_hex_record_parser.sv =====
// Top level of the HEX record parser: front, token queue, back and config register.
//
//  channel   direction  handshake               payload
//  char      in         char_valid/char_stall   char_code
//  cfg       in         cfg_valid/cfg_ready     cfg_data (word_addressing)
//  res       out        res_valid/res_stall     result_kind .. end_of_file
//
// One character is taken per cycle when the token queue has room; a result
// passes through the queue and then the result register. Sustained rate is
// one character per cycle while results are not stalled, set by the byte
// update in the back end. A stalled result holds while the queue (four
// tokens) keeps absorbing characters; char_stall rises once it fills.
// Reset clears all parse state, the linear base, and sets word addressing.
`timescale 1ns / 1ps

module intel_hex_record_parser import ihex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        result_kind,
	output logic [31:0] byte_address,
	output logic [7:0]  data_value,
	output logic [7:0]  record_type_out,
	output logic        checksum_good,
	output logic        end_of_file
);

	logic    word_addressing_q;
	logic    push;
	token_t  push_tok;
	logic    fifo_full;
	logic    tok_valid;
	token_t  tok;
	logic    pop;
	result_t res;

	// Always ready; the sender must write the configuration only while no
	// character is in flight (unenforced); a write acts from the next character.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_addressing_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			word_addressing_q <= cfg_data;
		end
	end

	// Front: decode characters into start and byte tokens.
	ihex_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.push       (push),
		.push_tok   (push_tok),
		.fifo_full  (fifo_full)
	);

	// Queue: lets the front keep taking characters while a result is stalled.
	ihex_token_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (push_tok),
		.full      (fifo_full),
		.tok_valid (tok_valid),
		.tok       (tok),
		.pop       (pop)
	);

	// Back: advance the record fields and load the result register.
	ihex_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.word_addressing (word_addressing_q),
		.tok_valid       (tok_valid),
		.tok             (tok),
		.pop             (pop),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.res             (res)
	);

	assign result_kind     = res.kind;
	assign byte_address    = res.addr;
	assign data_value      = res.data;
	assign record_type_out = res.rtype;
	assign checksum_good   = res.good;
	assign end_of_file     = res.eof;

endmodule

// ===== verif/intel_hex_record_parser_tb.sv =====
// Self-checking testbench for the Intel HEX record parser: random HEX text against a scoreboard.
`timescale 1ns / 1ps

module intel_hex_record_parser_tb;
	import ihex_pkg::*;

	// Record types the generator uses beyond the ones the package names, and the line end character.
	localparam logic [7:0] REC_EXT_SEG   = 8'h02;
	localparam logic [7:0] REC_START_SEG = 8'h03;
	localparam logic [7:0] REC_START_LIN = 8'h05;
	localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;

	localparam int PHASE_CHARS  = 400;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LENGTH,
		PH_OFFSET_HI,
		PH_OFFSET_LO,
		PH_TYPE,
		PH_DATA,
		PH_CHECKSUM
	} parse_phase_e;

	// Scoreboard: tracks the record being parsed and queues the results it implies.
	class record_scoreboard;
		logic         word_mode;
		parse_phase_e phase;
		logic         nib_pending;
		logic [3:0]   hi_nib;
		logic [7:0]   rec_len;
		logic [7:0]   remaining;
		logic [7:0]   rec_type;
		logic [7:0]   byte_sum;
		logic [15:0]  load_ofs;
		logic [15:0]  upper_base;
		logic [15:0]  base_pending;
		result_t      expected_q[$];
		int           mismatches;
		int           records_closed;
		int           records_good;
		int           data_bytes;

		function new();
			word_mode      = 1'b1;
			phase          = PH_IDLE;
			nib_pending    = 1'b0;
			hi_nib         = 4'h0;
			rec_len        = 8'h00;
			remaining      = 8'h00;
			rec_type       = 8'h00;
			byte_sum       = 8'h00;
			load_ofs       = 16'h0000;
			upper_base     = 16'h0000;
			base_pending   = 16'h0000;
			mismatches     = 0;
			records_closed = 0;
			records_good   = 0;
			data_bytes     = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_char(logic [7:0] c);
			logic [3:0]  nib;
			logic [7:0]  b;
			logic [7:0]  idx;
			logic [31:0] addr;
			result_t     r;
			if (c == CHAR_COLON) begin
				phase       = PH_LENGTH;
				nib_pending = 1'b0;
				hi_nib      = 4'h0;
				byte_sum    = 8'h00;
				return;
			end
			if (phase == PH_IDLE) begin
				return;
			end
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				nib = 4'(c - CHAR_ZERO);
			end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
				nib = 4'(c - CHAR_UC_A + DIGIT_TEN);
			end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
				nib = 4'(c - CHAR_LC_A + DIGIT_TEN);
			end else begin
				nib = 4'h0;
			end
			if (!nib_pending) begin
				hi_nib      = nib;
				nib_pending = 1'b1;
				return;
			end
			nib_pending = 1'b0;
			b           = {hi_nib, nib};
			byte_sum    = byte_sum + b;
			r           = '0;
			case (phase)
				PH_LENGTH: begin
					rec_len = b;
					phase   = PH_OFFSET_HI;
				end
				PH_OFFSET_HI: begin
					load_ofs = {b, 8'h00};
					phase    = PH_OFFSET_LO;
				end
				PH_OFFSET_LO: begin
					load_ofs[7:0] = b;
					phase         = PH_TYPE;
				end
				PH_TYPE: begin
					rec_type     = b;
					remaining    = rec_len;
					base_pending = 16'h0000;
					phase        = (rec_len != 8'h00) ? PH_DATA : PH_CHECKSUM;
				end
				PH_DATA: begin
					idx       = rec_len - remaining;
					remaining = remaining - 8'h01;
					if (remaining == 8'h00) begin
						phase = PH_CHECKSUM;
					end
					if (rec_type == REC_DATA) begin
						addr = ({upper_base, 16'h0000} + {16'h0000, load_ofs} + {24'h0, idx})
							& ADDR_MASK;
						if (word_mode) begin
							addr = addr >> 1;
						end
						r.kind = KIND_DATA;
						r.addr = addr;
						r.data = b;
						expected_q.push_back(r);
					end else if (rec_type == REC_EXT_LIN) begin
						if (idx == 8'd0) begin
							base_pending[15:8] = b;
						end else if (idx == 8'd1) begin
							base_pending[7:0] = b;
						end
					end
				end
				PH_CHECKSUM: begin
					r.kind  = KIND_REC_END;
					r.rtype = rec_type;
					r.good  = (byte_sum == 8'h00);
					r.eof   = (rec_type == REC_EOF);
					if (r.good && rec_type == REC_EXT_LIN) begin
						upper_base = base_pending;
					end
					expected_q.push_back(r);
					phase = PH_IDLE;
				end
				default: begin
					phase = PH_IDLE;
				end
			endcase
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				if (mismatches < MAX_REPORTS) begin
					$display("unexpected result: kind %0d addr %h data %h type %h good %0d eof %0d",
						got.kind, got.addr, got.data, got.rtype, got.good, got.eof);
				end
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			if (got.kind !== want.kind || got.addr !== want.addr || got.data !== want.data ||
					got.rtype !== want.rtype || got.good !== want.good || got.eof !== want.eof) begin
				if (mismatches < MAX_REPORTS) begin
					$display("mismatch: expected kind %0d addr %h data %h type %h good %0d eof %0d",
						want.kind, want.addr, want.data, want.rtype, want.good, want.eof);
					$display("          got      kind %0d addr %h data %h type %h good %0d eof %0d",
						got.kind, got.addr, got.data, got.rtype, got.good, got.eof);
				end
				mismatches++;
			end
			if (want.kind == KIND_REC_END) begin
				records_closed++;
				if (want.good) begin
					records_good++;
				end
			end else begin
				data_bytes++;
			end
		endfunction
	endclass

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [7:0]  char_code  = 8'h00;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic        cfg_data   = 1'b0;
	logic        res_valid;
	logic        res_stall  = 1'b0;
	logic        result_kind;
	logic [31:0] byte_address;
	logic [7:0]  data_value;
	logic [7:0]  record_type_out;
	logic        checksum_good;
	logic        end_of_file;

	record_scoreboard sb;
	bit  quiet_tail  = 1'b0;
	int  stall_left  = 0;
	int  chars_sent  = 0;
	int  cycle_count = 0;

	intel_hex_record_parser dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_valid      (char_valid),
		.char_stall      (char_stall),
		.char_code       (char_code),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.result_kind     (result_kind),
		.byte_address    (byte_address),
		.data_value      (data_value),
		.record_type_out (record_type_out),
		.checksum_good   (checksum_good),
		.end_of_file     (end_of_file)
	);

	always #10 clk = ~clk;

	// Hard stop: a hung handshake must not run forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver backpressure: random stall bursts, none in the tail.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			res_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			res_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Result monitor: sample the pre-edge values, so a transfer is valid high with stall low.
	always @(posedge clk) begin : result_monitor
		result_t got;
		if (arst_n && res_valid && !res_stall) begin
			got.kind  = result_kind;
			got.addr  = byte_address;
			got.data  = data_value;
			got.rtype = record_type_out;
			got.good  = checksum_good;
			got.eof   = end_of_file;
			sb.check_result(got);
		end
	end

	// Offer one character and hold it until the parser takes it. Valid stays high
	// afterward so back-to-back characters stream; callers that pause drop it first.
	task automatic send_char(input logic [7:0] c);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_code  <= c;
		do @(posedge clk); while (char_stall);
		sb.note_char(c);
		chars_sent++;
	endtask

	// Drop valid, let every expected result arrive, then give the token queue
	// and result register time to flush characters that produce nothing.
	task automatic drain();
		char_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Change word addressing only with the parser idle.
	task automatic write_word_mode(input logic mode);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.word_mode = mode;
	endtask

	// Build one record with a random type, size and content, mostly with a correct
	// checksum, then sometimes corrupt or truncate it. Report the record characters sent.
	task automatic send_record(output int sent);
		logic [7:0]  rec[$];
		logic [7:0]  line[$];
		int          len;
		int          pick;
		int          cut;
		logic [7:0]  rtype;
		logic [7:0]  sum;
		logic [15:0] ofs;
		logic [3:0]  nib;
		logic [7:0]  ch;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			rtype = REC_DATA;
			len   = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 255) : $urandom_range(0, 16);
		end else if (pick < 75) begin
			// Extended linear: cover missing, odd and extra base bytes.
			rtype = REC_EXT_LIN;
			len   = $urandom_range(0, 4);
		end else if (pick < 80) begin
			rtype = REC_EOF;
			len   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
		end else if (pick < 92) begin
			case ($urandom_range(0, 2))
				0:       rtype = REC_EXT_SEG;
				1:       rtype = REC_START_SEG;
				default: rtype = REC_START_LIN;
			endcase
			len = $urandom_range(0, 4);
		end else begin
			rtype = 8'($urandom_range(0, 255));
			len   = $urandom_range(0, 8);
		end
		// Bias some offsets to the top of the page to hit address carry and wrap.
		ofs = ($urandom_range(0, 7) == 0) ? (16'hFFF0 | 16'($urandom_range(0, 15))) : 16'($urandom);
		rec.push_back(8'(len));
		rec.push_back(ofs[15:8]);
		rec.push_back(ofs[7:0]);
		rec.push_back(rtype);
		for (int i = 0; i < len; i++) begin
			rec.push_back((rtype == REC_EXT_LIN && $urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
		end
		sum = 8'h00;
		foreach (rec[i]) begin
			sum = sum + rec[i];
		end
		sum = 8'h00 - sum;
		if ($urandom_range(0, 9) == 0) begin
			sum = sum ^ 8'($urandom_range(1, 255));
		end
		rec.push_back(sum);
		// Encode as text, mixing upper and lower case digits.
		line.push_back(CHAR_COLON);
		foreach (rec[i]) begin
			for (int k = 0; k < 2; k++) begin
				nib = (k == 0) ? rec[i][7:4] : rec[i][3:0];
				if (nib < 4'd10) begin
					ch = CHAR_ZERO + {4'h0, nib};
				end else begin
					ch = ($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + {4'h0, nib} - DIGIT_TEN;
				end
				line.push_back(ch);
			end
		end
		// Noise: a stray character anywhere after the colon, or a record cut short by the next colon.
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			line[$urandom_range(1, line.size() - 1)] = 8'($urandom);
		end else if (pick < 10) begin
			cut = $urandom_range(1, line.size() - 1);
			while (line.size() > cut) begin
				void'(line.pop_back());
			end
		end
		sent = line.size();
		foreach (line[i]) begin
			send_char(line[i]);
		end
		// Separator: usually a line end, sometimes junk text between records.
		if ($urandom_range(0, 3) == 0) begin
			ch = 8'($urandom);
			if (ch == CHAR_COLON) begin
				ch = CHAR_NEWLINE;
			end
			send_char(ch);
		end else begin
			send_char(CHAR_NEWLINE);
		end
	endtask

	initial begin
		int    phase_idx;
		int    budget;
		int    n;
		bit    paused;
		string directed;
		sb     = new();
		paused = 1'b0;
		// Abandoned record, empty end-of-file record, then a data byte at the top
		// offset written with non-hex digits and a matching checksum.
		directed = ":0:00000001FF\n:01FFFF00zZG1\n";
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < directed.len(); i++) begin
			send_char(directed[i]);
		end

		// Random phases alternate word addressing; the last one runs with no idling.
		for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
			write_word_mode(phase_idx[0]);
			if (phase_idx == 3) begin
				quiet_tail = 1'b1;
			end
			budget = 0;
			while (budget < PHASE_CHARS) begin
				send_record(n);
				budget += n;
				// Hold the sender once mid-phase until the parser has caught up.
				if (phase_idx == 1 && !paused && budget >= PHASE_CHARS / 2) begin
					drain();
					paused = 1'b1;
				end
			end
		end
		drain();

		$display("Sent %0d characters of HEX text with word addressing off and on.", chars_sent);
		$display("Checked %0d data bytes and %0d record ends, %0d with a good checksum.",
			sb.data_bytes, sb.records_closed, sb.records_good);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results still expected", sb.mismatches, sb.pending());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
